// ===== hdl/werc_pkg.sv =====
// ----------------------------------------------------------------------------
// werc_pkg
// Shared types and constants for the windowed event rate counter: controller
// states, command and status structs, and fixed field widths.
// ----------------------------------------------------------------------------
package werc_pkg;

    localparam int NOW_W     = 32;
    localparam int CNT_W     = 32;
    localparam int TYPE_W    = 4;

    // slot number: cycles of the reciprocal multiply pipeline
    localparam int DIV_ITERS = 4;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    localparam logic [NOW_W:0] STALE_SECONDS = 33'd900;
    localparam int BACK_NEWEST = 1;
    localparam int BACK_1M     = 20;
    localparam int BACK_5M     = 100;

    localparam logic [TYPE_W-1:0] FIRST_COUNTED = 4'd3;
    localparam logic [TYPE_W-1:0] LAST_COUNTED  = 4'd6;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_TIME,
        ST_WALK,
        ST_COMMIT,
        ST_RD_NEWEST,
        ST_RD_1M,
        ST_RD_5M,
        ST_RD_15M,
        ST_RD_LAST,
        ST_BUMP,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_1M,
        RD_5M,
        RD_15M
    } t_rd_sel;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_NEWEST,
        CAP_1M,
        CAP_5M,
        CAP_15M
    } t_cap;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    walk_init;
        logic    walk_step;
        logic    commit_time;
        logic    bump_type;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_cap    cap;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic is_bad;
        logic is_counted;
        logic div_last;
        logic walk_done;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/werc_ctrl.sv =====
// ----------------------------------------------------------------------------
// werc_ctrl
// Sequencing state machine: clearing pass, slot number division, slot walk,
// window reads and result hand-off, driven through the datapath commands.
// ----------------------------------------------------------------------------
module werc_ctrl
    import werc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_NEWEST;
        o_cmd.cap    = CAP_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.is_query || i_status.is_counted) begin
                    n_state = ST_DIV;
                end else if (i_status.is_bad) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_BUMP;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_TIME;
                end
            end
            ST_TIME: begin
                o_cmd.walk_init = 1'b1;
                n_state         = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit_time = 1'b1;
                o_cmd.bump_type   = 1'b1;
                n_state = i_status.is_query ? ST_RD_NEWEST : ST_FINISH;
            end
            ST_RD_NEWEST: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEWEST;
                n_state      = ST_RD_1M;
            end
            ST_RD_1M: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_1M;
                o_cmd.cap    = CAP_NEWEST;
                n_state      = ST_RD_5M;
            end
            ST_RD_5M: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_5M;
                o_cmd.cap    = CAP_1M;
                n_state      = ST_RD_15M;
            end
            ST_RD_15M: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_15M;
                o_cmd.cap    = CAP_5M;
                n_state      = ST_RD_LAST;
            end
            ST_RD_LAST: begin
                o_cmd.cap = CAP_15M;
                n_state   = ST_FINISH;
            end
            ST_BUMP: begin
                o_cmd.bump_type = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/werc_dpath.sv =====
// ----------------------------------------------------------------------------
// werc_dpath
// Datapath: input latch, slot number divider, slot ring memory and walker,
// running total, per-type counters, window differences and output register.
// ----------------------------------------------------------------------------
module werc_dpath
    import werc_pkg::*;
#(
    parameter int NUM_SLOTS    = 300,
    parameter int SLOT_SECONDS = 3,
    parameter int EVENT_TYPES  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_func,
    input  logic [TYPE_W-1:0] i_event_type,
    input  logic [NOW_W-1:0]  i_now_seconds,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CNT_W-1:0]  o_count_1m,
    output logic [CNT_W-1:0]  o_count_5m,
    output logic [CNT_W-1:0]  o_count_15m,
    output logic [CNT_W-1:0]  o_type_count,
    output logic              o_event_dropped
);

    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int TYPE_IDX_W = $clog2(EVENT_TYPES);
    localparam int PERIOD     = NUM_SLOTS * SLOT_SECONDS;
    localparam int PER_SH     = $clog2(PERIOD);
    localparam int SS_SH      = $clog2(SLOT_SECONDS);
    localparam int LO_W       = 16;

    localparam logic [SLOT_W:0]   NS        = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [TYPE_W:0]   NT        = (TYPE_W + 1)'(EVENT_TYPES);

    // rounded-up reciprocals, exact for every dividend of the given width
    localparam logic [NOW_W:0] PER_RECIP = (NOW_W + 1)'(
        ((64'd1 << (NOW_W + PER_SH)) + 64'(PERIOD - 1)) / 64'(PERIOD));
    localparam logic [LO_W-1:0]     RECIP_LO = PER_RECIP[LO_W-1:0];
    localparam logic [NOW_W-LO_W:0] RECIP_HI = PER_RECIP[NOW_W:LO_W];
    localparam logic [PER_SH:0]     SS_RECIP = (PER_SH + 1)'(
        ((64'd1 << (PER_SH + SS_SH)) + 64'(SLOT_SECONDS - 1)) / 64'(SLOT_SECONDS));

    // latched transaction
    logic              r_func;
    logic [TYPE_W-1:0] r_type;
    logic [NOW_W-1:0]  r_now;

    // slot number pipeline
    logic [NOW_W+LO_W-1:0] r_prod_lo;
    logic [NOW_W-1:0]      r_quo;
    logic [PER_SH-1:0]     r_per_rem;
    logic [SLOT_W-1:0]     r_div_qm;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [2*NOW_W:0]      quo_sum;
    logic [2*NOW_W:0]      quo_shift;
    logic [NOW_W-1:0]      quo_period;
    logic [NOW_W-1:0]      per_rem_full;
    logic [2*PER_SH:0]     slot_prod;
    logic [2*PER_SH:0]     slot_shift;

    // time state and walker
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_prev;
    logic [NOW_W-1:0]  r_last;
    logic [CNT_W-1:0]  r_total;
    logic [SLOT_W-1:0] r_wptr;
    logic              r_wfull;
    logic              walk_done;
    logic              walk_we;
    logic              stale;

    // slot ring
    logic [CNT_W-1:0]  r_slots [NUM_SLOTS];
    logic [CNT_W-1:0]  r_rdata;
    logic [SLOT_W-1:0] rd_addr;

    // window captures
    logic [CNT_W-1:0] r_newest;
    logic [CNT_W-1:0] r_d1m;
    logic [CNT_W-1:0] r_d5m;
    logic [CNT_W-1:0] r_d15m;

    // type counters
    logic [CNT_W-1:0]      r_cnt [EVENT_TYPES];
    logic [TYPE_IDX_W-1:0] type_idx;
    logic                  type_ok;
    logic                  counted;
    logic [CNT_W-1:0]      type_sel;

    logic r_ovalid;

    function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] cur,
                                                    input logic [SLOT_W:0]   back);
        logic [SLOT_W:0] s;
        s = {1'b0, cur} + NS - back;
        if (s >= NS) begin
            s = s - NS;
        end
        return s[SLOT_W-1:0];
    endfunction

    // ---------------- transaction latch ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_type <= i_event_type;
            r_now  <= i_now_seconds;
        end
    end

    assign type_idx = r_type[TYPE_IDX_W-1:0];
    assign type_ok  = ({1'b0, r_type} < NT);
    assign counted  = (r_func == FUNC_EVENT) && type_ok &&
                      (r_type >= FIRST_COUNTED) && (r_type <= LAST_COUNTED);

    // ---------------- slot number: (now / SLOT_SECONDS) mod NUM_SLOTS ----------------
    // equals (now mod NUM_SLOTS*SLOT_SECONDS) / SLOT_SECONDS; one stage per cycle:
    // low partial product, quotient by the period, remainder, slot number
    assign quo_sum      = (((2*NOW_W+1)'(r_now) * (2*NOW_W+1)'(RECIP_HI)) << LO_W) +
                          (2*NOW_W+1)'(r_prod_lo);
    assign quo_shift    = quo_sum >> (NOW_W + PER_SH);
    assign quo_period   = r_quo * NOW_W'(PERIOD);
    assign per_rem_full = r_now - quo_period;
    assign slot_prod    = (2*PER_SH+1)'(r_per_rem) * (2*PER_SH+1)'(SS_RECIP);
    assign slot_shift   = slot_prod >> (PER_SH + SS_SH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_prod_lo <= (NOW_W+LO_W)'(r_now) * (NOW_W+LO_W)'(RECIP_LO);
            r_quo     <= quo_shift[NOW_W-1:0];
            r_per_rem <= per_rem_full[PER_SH-1:0];
            r_div_qm  <= slot_shift[SLOT_W-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // ---------------- time state and slot walker ----------------
    assign stale     = (({1'b0, r_last} + STALE_SECONDS) < {1'b0, r_now});
    assign walk_done = (r_wptr == r_cur) && !r_wfull;
    assign walk_we   = i_cmd.walk_step && !walk_done;

    // full pass starts at the current slot and goes all the way round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_wptr  <= '0;
            r_wfull <= 1'b1;
        end else if (i_cmd.walk_init) begin
            r_cur   <= r_div_qm;
            r_wptr  <= stale ? r_div_qm : r_prev;
            r_wfull <= stale;
        end else if (walk_we) begin
            r_wptr  <= (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
            r_wfull <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_last  <= '0;
            r_total <= '0;
        end else if (i_cmd.commit_time) begin
            r_prev <= r_cur;
            r_last <= r_now;
            if (r_func == FUNC_EVENT) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // ---------------- slot ring memory ----------------
    always_comb begin
        case (i_cmd.rd_sel)
            RD_NEWEST: rd_addr = ring_back(r_cur, (SLOT_W + 1)'(BACK_NEWEST));
            RD_1M:     rd_addr = ring_back(r_cur, (SLOT_W + 1)'(BACK_1M));
            RD_5M:     rd_addr = ring_back(r_cur, (SLOT_W + 1)'(BACK_5M));
            RD_15M:    rd_addr = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
            default:   rd_addr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (walk_we) begin
            r_slots[r_wptr] <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_slots[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            CAP_NEWEST: r_newest <= r_rdata;
            CAP_1M:     r_d1m    <= r_newest - r_rdata;
            CAP_5M:     r_d5m    <= r_newest - r_rdata;
            CAP_15M:    r_d15m   <= r_newest - r_rdata;
            default: begin
            end
        endcase
    end

    // ---------------- type counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < EVENT_TYPES; j++) begin
                r_cnt[j] <= '0;
            end
        end else if (i_cmd.bump_type && (r_func == FUNC_EVENT) && type_ok) begin
            r_cnt[type_idx] <= r_cnt[type_idx] + 1'b1;
        end
    end

    assign type_sel = type_ok ? r_cnt[type_idx] : '0;

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_count_1m      <= (r_func == FUNC_QUERY) ? r_d1m  : '0;
            o_count_5m      <= (r_func == FUNC_QUERY) ? r_d5m  : '0;
            o_count_15m     <= (r_func == FUNC_QUERY) ? r_d15m : '0;
            o_type_count    <= type_sel;
            o_event_dropped <= (r_func == FUNC_EVENT) && !type_ok;
        end
    end

    assign o_out_valid = r_ovalid;

    assign o_status.is_query   = (r_func == FUNC_QUERY);
    assign o_status.is_bad     = (r_func == FUNC_EVENT) && !type_ok;
    assign o_status.is_counted = counted;
    assign o_status.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_ITERS - 1));
    assign o_status.walk_done  = walk_done;
    assign o_status.out_free   = !r_ovalid || i_out_ready;

`ifndef SYNTHESIS
    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_we |-> ({1'b0, r_wptr} < NS))
        else $error("slot walker beyond ring");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_out_ready))
        else $error("result loaded over a pending transaction");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_time && (r_func == FUNC_EVENT)) |=> (r_total == $past(r_total) + 1'b1))
        else $error("running total not advanced on counted event");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd_en && i_cmd.walk_step))
        else $error("slot ring read during walk");
`endif

endmodule

// ===== hdl/windowed_event_rate_counter.sv =====
// ----------------------------------------------------------------------------
// windowed_event_rate_counter
// Counts typed events and reports how much the counted-event total grew over
// 1, 5 and 15 minute windows held in a ring of time slots.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready    | i_func, i_event_type, i_now_seconds
//  output   | o_out_valid / i_out_ready  | o_count_1m, o_count_5m, o_count_15m,
//           |                            | o_type_count, o_event_dropped
//
//  one transaction at a time; an uncounted or dropped event skips the slot number
//  divider and the slot walk; a counted event or a query runs the reciprocal
//  multiply for the slot number, then walks the slot ring at one write a cycle
//  over 0 up to NUM_SLOTS slots, and a query then reads the four window slots
//  after reset a clearing pass writes all NUM_SLOTS slots before the first
//  transaction is taken
//  a stalled result sits in the output register; the next transaction is taken
//  meanwhile and waits only at its own hand-off
// ----------------------------------------------------------------------------
module windowed_event_rate_counter
    import werc_pkg::*;
#(
    parameter int NUM_SLOTS    = 300,
    parameter int SLOT_SECONDS = 3,
    parameter int EVENT_TYPES  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [TYPE_W-1:0] i_event_type,
    input  logic [NOW_W-1:0]  i_now_seconds,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CNT_W-1:0]  o_count_1m,
    output logic [CNT_W-1:0]  o_count_5m,
    output logic [CNT_W-1:0]  o_count_15m,
    output logic [CNT_W-1:0]  o_type_count,
    output logic              o_event_dropped
);

    t_cmd    cmd;
    t_status status;

    werc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    werc_dpath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .SLOT_SECONDS (SLOT_SECONDS),
        .EVENT_TYPES  (EVENT_TYPES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (i_func),
        .i_event_type    (i_event_type),
        .i_now_seconds   (i_now_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_count_1m      (o_count_1m),
        .o_count_5m      (o_count_5m),
        .o_count_15m     (o_count_15m),
        .o_type_count    (o_type_count),
        .o_event_dropped (o_event_dropped)
    );

endmodule

// ===== tb/sv/tb_rate_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rate_scoreboard_pkg
// Expected-count bookkeeping for the windowed event rate counter: keeps its
// own slot ring, running total and per-type counters, works out the counts
// each accepted transaction should return and checks results in order.
// ----------------------------------------------------------------------------
package tb_rate_scoreboard_pkg;

    import werc_pkg::*;

    localparam int unsigned SLOT_COUNT     = 300;
    localparam int unsigned SLOT_SECS      = 3;
    localparam int unsigned EVENT_KINDS    = 8;
    localparam int unsigned WIN_1M_SLOTS   = 20;
    localparam int unsigned WIN_5M_SLOTS   = 100;
    localparam logic [NOW_W:0] STALE_LIMIT = 33'd900;
    localparam logic [TYPE_W-1:0] KIND_COUNTED_LO = 4'd3;
    localparam logic [TYPE_W-1:0] KIND_COUNTED_HI = 4'd6;

    typedef struct {
        logic [CNT_W-1:0] count_1m;
        logic [CNT_W-1:0] count_5m;
        logic [CNT_W-1:0] count_15m;
        logic [CNT_W-1:0] type_count;
        logic             event_dropped;
    } t_rate_counts;

    class t_rate_scoreboard;

        logic [CNT_W-1:0] slot_totals [SLOT_COUNT];
        logic [CNT_W-1:0] type_counters [EVENT_KINDS];
        logic [CNT_W-1:0] running_total;
        logic [NOW_W-1:0] last_seen;
        int unsigned      ring_prev;
        t_rate_counts     expected_counts [$];
        int unsigned      mismatches;

        function new();
            foreach (slot_totals[k]) slot_totals[k] = '0;
            foreach (type_counters[k]) type_counters[k] = '0;
            running_total = '0;
            last_seen     = '0;
            ring_prev     = 0;
            mismatches    = 0;
        endfunction

        // bring the slot ring up to the current time, then add to the total
        function int unsigned advance_clock(logic [NOW_W-1:0] now, logic [CNT_W-1:0] step);
            int unsigned cur;
            int unsigned k;
            cur = (now / SLOT_SECS) % SLOT_COUNT;
            if ({1'b0, last_seen} + STALE_LIMIT < {1'b0, now}) begin
                foreach (slot_totals[j]) slot_totals[j] = running_total;
                ring_prev = cur;
            end
            for (k = ring_prev; k != cur; k = (k + 1) % SLOT_COUNT)
                slot_totals[k] = running_total;
            ring_prev     = cur;
            running_total = running_total + step;
            last_seen     = now;
            return cur;
        endfunction

        function void note_item(logic func, logic [TYPE_W-1:0] kind, logic [NOW_W-1:0] now);
            t_rate_counts     want;
            int unsigned      cur;
            logic [CNT_W-1:0] newest;
            want = '{default: '0};
            if (func == FUNC_QUERY) begin
                cur    = advance_clock(now, '0);
                newest = slot_totals[(cur + SLOT_COUNT - 1) % SLOT_COUNT];
                want.count_1m  = newest - slot_totals[(cur + SLOT_COUNT - WIN_1M_SLOTS) % SLOT_COUNT];
                want.count_5m  = newest - slot_totals[(cur + SLOT_COUNT - WIN_5M_SLOTS) % SLOT_COUNT];
                want.count_15m = newest - slot_totals[(cur + 1) % SLOT_COUNT];
                if (kind < EVENT_KINDS)
                    want.type_count = type_counters[kind];
            end else if (kind >= EVENT_KINDS) begin
                want.event_dropped = 1'b1;
            end else begin
                if (kind >= KIND_COUNTED_LO && kind <= KIND_COUNTED_HI)
                    void'(advance_clock(now, 1));
                type_counters[kind] = type_counters[kind] + 1;
                want.type_count     = type_counters[kind];
            end
            expected_counts.push_back(want);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_counts(t_rate_counts got);
            t_rate_counts want;
            if (expected_counts.size() == 0) begin
                $error("result transaction with nothing outstanding");
                mismatches++;
                return;
            end
            want = expected_counts.pop_front();
            compare_field("count_1m", want.count_1m, got.count_1m);
            compare_field("count_5m", want.count_5m, got.count_5m);
            compare_field("count_15m", want.count_15m, got.count_15m);
            compare_field("type_count", want.type_count, got.type_count);
            compare_field("event_dropped", CNT_W'(want.event_dropped), CNT_W'(got.event_dropped));
        endfunction

        function bit drained();
            return expected_counts.size() == 0;
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives event reports and totals queries into the windowed event rate
// counter with random gaps and back-pressure, and checks every result against
// the scoreboard's own prediction of the slot ring and type counters.
// ----------------------------------------------------------------------------
module tb_top;

    import werc_pkg::*;
    import tb_rate_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 1930;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_func   = 1'b0;
    logic [TYPE_W-1:0] in_type   = '0;
    logic [NOW_W-1:0]  in_now    = '0;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [CNT_W-1:0]  count_1m;
    logic [CNT_W-1:0]  count_5m;
    logic [CNT_W-1:0]  count_15m;
    logic [CNT_W-1:0]  type_count;
    logic              event_dropped;

    bit gaps_on       = 1'b1;
    int hold_requests = 0;

    t_rate_scoreboard sb = new();

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    windowed_event_rate_counter #(
        .NUM_SLOTS    (SLOT_COUNT),
        .SLOT_SECONDS (SLOT_SECS),
        .EVENT_TYPES  (EVENT_KINDS)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (in_func),
        .i_event_type    (in_type),
        .i_now_seconds   (in_now),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_count_1m      (count_1m),
        .o_count_5m      (count_5m),
        .o_count_15m     (count_15m),
        .o_type_count    (type_count),
        .o_event_dropped (event_dropped)
    );

    // within this task valid is only lowered when a gap is taken, so back-to-back
    // transactions never see a drop and rise in the same step
    task automatic send_item(input logic func, input logic [TYPE_W-1:0] kind,
                             input logic [NOW_W-1:0] now);
        while (gaps_on && $urandom_range(0, 99) < 25) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_type  <= kind;
        in_now   <= now;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sb.note_item(func, kind, now);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (!sb.drained());
    endtask

    initial begin : result_side
        t_rate_counts got;
        int           hold_left;
        int           served;
        hold_left = 0;
        served    = 0;
        forever begin
            @(posedge clk);
            if (out_ready && out_valid === 1'b1) begin
                got.count_1m      = count_1m;
                got.count_5m      = count_5m;
                got.count_15m     = count_15m;
                got.type_count    = type_count;
                got.event_dropped = event_dropped;
                sb.check_counts(got);
            end
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(gaps_on && $urandom_range(0, 99) < 25);
            end
        end
    end

    initial begin : stimulus
        logic [NOW_W-1:0]  now_base;
        logic [TYPE_W-1:0] kind;
        logic              func;
        int                k;
        int                r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening: every type, dropped codes, window edges and odd times
        send_item(FUNC_QUERY, 4'd0, 32'd0);
        for (k = 0; k < EVENT_KINDS; k++)
            send_item(FUNC_EVENT, TYPE_W'(k), 32'd5);
        send_item(FUNC_EVENT, 4'd8, 32'd5);
        send_item(FUNC_EVENT, 4'd15, 32'd6);
        send_item(FUNC_QUERY, 4'd15, 32'd7);
        send_item(FUNC_QUERY, 4'd3, 32'd60);
        send_item(FUNC_EVENT, 4'd4, 32'd2000);           // stale: whole ring refilled
        send_item(FUNC_EVENT, 4'd5, 32'd2900);           // exactly at the stale limit
        send_item(FUNC_QUERY, 4'd5, 32'd2950);
        send_item(FUNC_QUERY, 4'd7, 32'd100);            // time stepping back
        send_item(FUNC_EVENT, 4'd6, 32'hFFFF_FFFF);
        send_item(FUNC_QUERY, 4'd6, 32'hFFFF_FFFF);
        send_item(FUNC_EVENT, 4'd3, 32'h5555_5555);
        send_item(FUNC_QUERY, 4'd4, 32'hAAAA_AAAA);

        now_base = 32'hAAAA_AAAA;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            gaps_on = !(k >= 700 && k < 1000);
            if (k == 400)
                hold_requests++;
            if (k == 1300) begin
                in_valid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(0, 999);
            if (r < 600)
                now_base = now_base + $urandom_range(0, 4);
            else if (r < 850)
                now_base = now_base + $urandom_range(5, 70);
            else if (r < 940)
                now_base = now_base + $urandom_range(71, 900);
            else if (r < 970)
                now_base = now_base + $urandom_range(901, 5000);
            else if (r < 985)
                now_base = now_base - $urandom_range(1, 300);
            else
                now_base = $urandom();
            func = ($urandom_range(0, 2) == 0) ? FUNC_QUERY : FUNC_EVENT;
            if ($urandom_range(0, 9) == 0)
                kind = TYPE_W'($urandom_range(8, 15));
            else
                kind = TYPE_W'($urandom_range(0, 7));
            send_item(func, kind, now_base);
        end

        in_valid <= 1'b0;
        gaps_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("windowed_event_rate_counter test passed");
        else
            $display("windowed_event_rate_counter test failed");
        $finish;
    end

    // worst case is every transaction walking the full ring plus stalls
    initial begin : watchdog
        #32_000_000;
        $display("windowed_event_rate_counter test failed");
        $finish;
    end

endmodule
